### sv/rta_pkg.sv
package rta_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic latch;
    logic clr;
    logic ref_rd;
    logic ref_wr;
    logic pop_rd;
    logic pop_wr;
    logic mod_start;
    logic mod_v;
    logic spl_rd;
    logic spl_wr;
    logic rel_fin;
    logic alc_fin;
    logic lk_rd;
    logic lk_fin;
    logic exh;
    logic ovf;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       cnt_zero;
    logic       cnt_full;
    logic       g_zero;
    logic       g_ovf;
    logic       ref_last;
    logic       spl_last;
    logic       mod_done;
    logic       out_free;
    logic [1:0] op;
  } sts_t;

endpackage

### sv/rta_mod.sv
module rta_mod #(
  parameter int SLOTS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              din,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] rem
);
  localparam int SW = $clog2(SLOTS);

  generate
    if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          rem <= din[SW-1:0];
        end
      end
    end else begin : g_recip
      // floor(2^K / SLOTS) undershoots the quotient by at most one
      localparam int          K     = 32 + SW;
      localparam logic [32:0] RECIP = 33'((64'd1 << K) / 64'(SLOTS));

      logic [31:0] x_q;
      logic [64:0] prod_q;
      logic [31:0] qs_q;
      logic [2:0]  pipe;
      logic [31:0] quo;
      logic [32:0] diff;

      assign quo  = 32'(prod_q >> K);
      assign diff = {1'b0, x_q} - {1'b0, qs_q};

      always_ff @(posedge clk) begin
        if (rst) begin
          pipe <= '0;
          done <= 1'b0;
        end else begin
          pipe <= {pipe[1:0], start};
          done <= pipe[2];
        end
        if (start) begin
          x_q <= din;
        end
        if (pipe[0]) begin
          prod_q <= 65'(x_q) * 65'(RECIP);
        end
        if (pipe[1]) begin
          qs_q <= 32'(64'(quo) * 64'(SLOTS));
        end
        // one correction step brings the remainder into range
        if (pipe[2]) begin
          if (diff >= 33'(SLOTS)) begin
            rem <= SW'(diff - 33'(SLOTS));
          end else begin
            rem <= SW'(diff);
          end
        end
      end
    end
  endgenerate

endmodule

### sv/rta_datapath.sv
module rta_datapath #(
  parameter int SLOTS       = 256,
  parameter int CACHE_DEPTH = 16,
  parameter int REQUESTERS  = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rta_pkg::cmd_t             cmd,
  output rta_pkg::sts_t             sts,
  input  logic [rta_pkg::IN_W-1:0]  s_tdata,
  output logic [rta_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready
);
  import rta_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int GW  = $clog2(SLOTS + 1);
  localparam int H   = CACHE_DEPTH / 2;
  localparam int IW  = $clog2(H) + 1;
  localparam int CW  = $clog2(CACHE_DEPTH + 1);
  localparam int RW  = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int NC  = REQUESTERS * CACHE_DEPTH;
  localparam int CAW = $clog2(NC);

  logic [1:0]    op_q;
  logic [RW-1:0] req_q;
  logic [31:0]   tag_q;
  logic [RW-1:0] r_sel;
  logic [CW-1:0] cnt [REQUESTERS];
  logic [CW-1:0] cur_cnt;
  logic [GW-1:0] gcnt;
  logic [GW-1:0] lw;
  logic [GW-1:0] gbase;
  logic [IW-1:0] rn;
  logic [IW-1:0] idx;
  logic [31:0]   vreg;
  logic [31:0]   v;
  logic [2:0]    res_st;
  logic [31:0]   res_tag;
  logic [SW-1:0] clr_idx;

  logic [31:0]    gmem [SLOTS];
  logic [31:0]    gmem_q;
  logic [SW-1:0]  gp_q;
  logic [SW-1:0]  gra;
  logic [31:0]    gval;

  logic [31:0]    cmem [NC];
  logic [31:0]    cmem_q;
  logic [CAW-1:0] cbase;
  logic [CAW-1:0] cra;
  logic [CAW-1:0] cwa;
  logic [31:0]    cwd;

  logic [32:0]    smem [SLOTS];
  logic [32:0]    smem_q;
  logic [SW-1:0]  swa;
  logic [32:0]    swd;
  logic           swe;

  logic           mod_done;
  logic [SW-1:0]  rem;

  rta_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .din   (cmd.mod_v ? v : tag_q),
    .done  (mod_done),
    .rem   (rem)
  );

  // fold an out-of-range requester back into range
  always_comb begin
    if (REQUESTERS == 1) begin
      r_sel = '0;
    end else if (7'(s_tdata[3:2]) >= 7'(REQUESTERS)) begin
      r_sel = RW'(7'(s_tdata[3:2]) - 7'(REQUESTERS));
    end else begin
      r_sel = RW'(s_tdata[3:2]);
    end
  end

  assign cur_cnt = cnt[req_q];
  assign cbase   = CAW'(req_q * CACHE_DEPTH);
  assign gbase   = gcnt - GW'(rn);
  assign gra     = SW'(gbase + GW'(idx));

  // entries below the low-water mark were never written, so their initial value is computed
  assign gval = (GW'(gp_q) < lw) ? 32'(SLOTS - 1) - 32'(gp_q) : gmem_q;

  always_comb begin
    v = cmem_q + 32'(SLOTS);
    if (v == 32'd0) begin
      v = 32'(SLOTS);
    end
  end

  assign cra = cmd.pop_rd ? CAW'(cbase + CAW'(cur_cnt - CW'(1)))
                          : CAW'(cbase + CAW'(CACHE_DEPTH - H) + CAW'(idx));
  assign cwa = cmd.ref_wr ? CAW'(cbase + CAW'(idx)) : CAW'(cbase + CAW'(cur_cnt));
  assign cwd = cmd.ref_wr ? gval : tag_q;

  always_comb begin
    swe = cmd.clr | cmd.alc_fin | cmd.rel_fin;
    if (cmd.clr) begin
      swa = clr_idx;
      swd = '0;
    end else if (cmd.alc_fin) begin
      swa = rem;
      swd = {1'b1, vreg};
    end else begin
      swa = rem;
      swd = {1'b0, tag_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ref_wr || cmd.rel_fin) begin
      cmem[cwa] <= cwd;
    end
    if (cmd.pop_rd || cmd.spl_rd) begin
      cmem_q <= cmem[cra];
    end
    if (cmd.spl_wr) begin
      gmem[SW'(gcnt + GW'(idx))] <= cmem_q;
    end
    if (cmd.ref_rd) begin
      gmem_q <= gmem[gra];
      gp_q   <= gra;
    end
    if (swe) begin
      smem[swa] <= swd;
    end
    if (cmd.lk_rd) begin
      smem_q <= smem[rem];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REQUESTERS; i++) begin
        cnt[i] <= '0;
      end
      gcnt     <= GW'(SLOTS);
      lw       <= GW'(SLOTS);
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_idx <= clr_idx + SW'(1);
      end
      if (cmd.ref_wr && sts.ref_last) begin
        cnt[req_q] <= CW'(rn);
        gcnt       <= gbase;
        if (gbase < lw) begin
          lw <= gbase;
        end
      end
      if (cmd.pop_wr) begin
        cnt[req_q] <= cur_cnt - CW'(1);
      end
      if (cmd.spl_wr && sts.spl_last) begin
        cnt[req_q] <= CW'(CACHE_DEPTH - H);
        gcnt       <= gcnt + GW'(H);
      end
      if (cmd.rel_fin) begin
        cnt[req_q] <= cur_cnt + CW'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= s_tdata[1:0];
      req_q <= r_sel;
      tag_q <= s_tdata[35:4];
      idx   <= '0;
      rn    <= (32'(gcnt) < 32'(H)) ? IW'(gcnt) : IW'(H);
    end else if (cmd.ref_wr || cmd.spl_wr) begin
      idx <= sts.ref_last && cmd.ref_wr ? '0 : idx + IW'(1);
    end
    if (cmd.pop_wr) begin
      vreg <= v;
    end
    if (cmd.alc_fin) begin
      res_st  <= ST_OK;
      res_tag <= vreg;
    end else if (cmd.rel_fin) begin
      res_st  <= ST_OK;
      res_tag <= tag_q;
    end else if (cmd.exh) begin
      res_st  <= ST_EXHAUSTED;
      res_tag <= '0;
    end else if (cmd.ovf) begin
      res_st  <= ST_OVERFLOW;
      res_tag <= tag_q;
    end else if (cmd.lk_fin) begin
      res_tag <= tag_q;
      if (!smem_q[32]) begin
        res_st <= ST_NOT_FOUND;
      end else if (smem_q[31:0] != tag_q) begin
        res_st <= ST_MISMATCH;
      end else begin
        res_st <= ST_OK;
      end
    end
    if (cmd.emit) begin
      m_tdata <= {5'd0, res_tag, res_st};
    end
  end

  always_comb begin
    sts.clr_last = (clr_idx == SW'(SLOTS - 1));
    sts.cnt_zero = (cur_cnt == '0);
    sts.cnt_full = (cur_cnt == CW'(CACHE_DEPTH));
    sts.g_zero   = (gcnt == '0);
    sts.g_ovf    = (32'(gcnt) + 32'(H) > 32'(SLOTS));
    sts.ref_last = (idx == rn - IW'(1));
    sts.spl_last = (32'(idx) == 32'(H - 1));
    sts.mod_done = mod_done;
    sts.out_free = !m_tvalid || m_tready;
    sts.op       = op_q;
  end

endmodule

### sv/rta_ctrl.sv
module rta_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  rta_pkg::sts_t sts,
  output rta_pkg::cmd_t cmd
);
  import rta_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_REF_RD, S_REF_WR, S_POP_RD, S_POP_WR,
    S_MOD_WAIT, S_ALC_FIN, S_SPL_RD, S_SPL_WR, S_REL_FIN, S_LK_RD, S_LK_FIN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_ALLOC: begin
            if (!sts.cnt_zero) begin
              state_next = S_POP_RD;
            end else if (sts.g_zero) begin
              cmd.exh    = 1'b1;
              state_next = S_EMIT;
            end else begin
              state_next = S_REF_RD;
            end
          end
          OP_RELEASE: begin
            if (sts.cnt_full && sts.g_ovf) begin
              cmd.ovf    = 1'b1;
              state_next = S_EMIT;
            end else begin
              cmd.mod_start = 1'b1;
              state_next    = S_MOD_WAIT;
            end
          end
          default: begin
            cmd.mod_start = 1'b1;
            state_next    = S_MOD_WAIT;
          end
        endcase
      end
      S_REF_RD: begin
        cmd.ref_rd = 1'b1;
        state_next = S_REF_WR;
      end
      S_REF_WR: begin
        cmd.ref_wr = 1'b1;
        state_next = sts.ref_last ? S_POP_RD : S_REF_RD;
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.pop_wr    = 1'b1;
        cmd.mod_start = 1'b1;
        cmd.mod_v     = 1'b1;
        state_next    = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (sts.mod_done) begin
          unique case (sts.op)
            OP_ALLOC:   state_next = S_ALC_FIN;
            OP_RELEASE: state_next = sts.cnt_full ? S_SPL_RD : S_REL_FIN;
            default:    state_next = S_LK_RD;
          endcase
        end
      end
      S_ALC_FIN: begin
        cmd.alc_fin = 1'b1;
        state_next  = S_EMIT;
      end
      S_SPL_RD: begin
        cmd.spl_rd = 1'b1;
        state_next = S_SPL_WR;
      end
      S_SPL_WR: begin
        cmd.spl_wr = 1'b1;
        state_next = sts.spl_last ? S_REL_FIN : S_SPL_RD;
      end
      S_REL_FIN: begin
        cmd.rel_fin = 1'b1;
        state_next  = S_EMIT;
      end
      S_LK_RD: begin
        cmd.lk_rd  = 1'b1;
        state_next = S_LK_FIN;
      end
      S_LK_FIN: begin
        cmd.lk_fin = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == S_IDLE);
    end
  end

endmodule

### sv/request_tag_allocator.sv
// Channel | Dir | Fields (lowest bit up)
// s_*     | in  | tdata: op[1:0], requester[3:2], tag[35:4], zero pad to 40
// m_*     | out | tdata: status[2:0], tag_out[34:3], zero pad to 40
//
// One item at a time. An allocate from a non-empty cache pops an entry, then
// indexes its slot and writes it; a lookup indexes and reads the slot; a
// release indexes and writes the slot; an exhausted or overflow answer goes
// straight out. A cache refill first moves up to CACHE_DEPTH/2 entries in,
// a spill moves CACHE_DEPTH/2 entries out. Slot index is a mask when SLOTS
// is a power of two, else a reciprocal multiply. After reset the slot table
// is cleared before the first item is taken. A result not yet taken stays in the
// output register; the next item is accepted and worked, and its result waits.
module request_tag_allocator #(
  parameter int SLOTS       = 256,
  parameter int CACHE_DEPTH = 16,
  parameter int REQUESTERS  = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rta_pkg::IN_W-1:0]  s_tdata,  // op, requester, tag
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rta_pkg::OUT_W-1:0] m_tdata   // status, tag_out
);
  import rta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rta_datapath #(
    .SLOTS       (SLOTS),
    .CACHE_DEPTH (CACHE_DEPTH),
    .REQUESTERS  (REQUESTERS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in flight");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwrites one not yet taken");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> !s_tready)
    else $error("item taken during slot clearing");

endmodule
